// ===== hdl/dtmr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmr_pkg: shared types and constants of the dual interval timer
// Request and response structs, register map, control bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package dtmr_pkg;

  // Request kinds carried in the mode field; code 3 is unused.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  // Register word within one timer block; word 7 is unmapped.
  typedef enum logic [2:0] {
    REG_LOAD    = 3'd0,
    REG_VALUE   = 3'd1,
    REG_CONTROL = 3'd2,
    REG_INTCLR  = 3'd3,
    REG_RIS     = 3'd4,
    REG_MIS     = 3'd5,
    REG_BGLOAD  = 3'd6
  } reg_e;

  // Control register bit positions.
  localparam int unsigned CtlOneshot  = 0;
  localparam int unsigned CtlSize32   = 1;
  localparam int unsigned CtlPreLo    = 2;
  localparam int unsigned CtlPreHi    = 3;
  localparam int unsigned CtlIntEn    = 5;
  localparam int unsigned CtlFromLoad = 6;
  localparam int unsigned CtlEnable   = 7;

  localparam logic [7:0]  CTL_RESET = 8'h20;
  localparam logic [31:0] MAX16     = 32'h0000_FFFF;
  localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;

  // Prescaler settings and their division ratios.
  localparam logic [1:0] PRE_DIV16  = 2'd1;
  localparam logic [1:0] PRE_DIV256 = 2'd2;
  localparam logic [8:0] DIV1       = 9'd1;
  localparam logic [8:0] DIV16      = 9'd16;
  localparam logic [8:0] DIV256     = 9'd256;

  // Word offsets 1016..1023 hold the ID registers (upper seven bits all ones).
  localparam logic [6:0] ID_BLOCK = 7'h7F;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  word_offset;
    logic [31:0] write_data;
    logic        access_is_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_first;
    logic        irq_second;
    logic        access_error;
  } out_item_t;

  // Request to one timer, already decoded for size and block.
  typedef struct packed {
    logic        tick;
    logic        rd;
    logic        wr;
    reg_e        sel;
    logic [31:0] data;
  } unit_req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        err;
    logic        irq;
  } unit_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/dual_interval_timer.sv =====
// ----------------------------------------------------------------------------
// dual_interval_timer: two prescaled down-counting timers behind a register bank
// Requests are base-clock ticks, register reads and register writes; every
// request returns one response with read data, both interrupt lines and an
// access error flag.
//
// Usage:
// - Request channel in_valid_i / in_stall_o / in_req_i; response channel
//   out_valid_o / out_stall_i / out_rsp_o. A request moves on a rising edge
//   with valid high and stall low.
// - A request taken into the input register has its response written to the
//   response register when it advances, and the response is then valid.
// - Throughput: one request per cycle while the response is not stalled, set by
//   the combinational update of the timer state between the input and response registers.
// - When the receiver stalls, the response register holds; the input
//   register takes one more request, then in_stall_o rises until the
//   response is taken.
// - Reset clears both stages and sets each timer to its reset state
//   (control 0x20, value all ones, everything else zero).
// - Interrupt lines in a response reflect the state after that request.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_interval_timer #(
  parameter int unsigned NUM_UNITS = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dtmr_pkg::in_item_t  in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dtmr_pkg::out_item_t      out_rsp_o
);

  localparam logic HasSecond = (NUM_UNITS > 1);

  // Input stage.
  logic               in_valid_q;
  dtmr_pkg::in_item_t in_q;
  // Response stage.
  logic                out_valid_q;
  dtmr_pkg::out_item_t out_q, out_d;

  logic advance;

  // Advance whenever the response register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // Decode the request.
  logic is_tick, is_rd, is_wr, acc, unit_ok, id_word;

  assign is_tick = (dtmr_pkg::mode_e'(in_q.mode) == dtmr_pkg::MODE_TICK);
  assign is_rd   = (dtmr_pkg::mode_e'(in_q.mode) == dtmr_pkg::MODE_READ);
  assign is_wr   = (dtmr_pkg::mode_e'(in_q.mode) == dtmr_pkg::MODE_WRITE);
  assign acc     = is_rd || is_wr;
  // Timer blocks live in words 0..15; the second only if it exists.
  assign unit_ok = (in_q.word_offset[9:4] == '0) && (!in_q.word_offset[3] || HasSecond);
  assign id_word = (in_q.word_offset[9:3] == dtmr_pkg::ID_BLOCK);

  dtmr_pkg::unit_req_t ureq [NUM_UNITS];
  dtmr_pkg::unit_rsp_t ursp [NUM_UNITS];

  for (genvar u = 0; u < NUM_UNITS; u++) begin : g_unit
    logic hit;
    assign hit = in_q.access_is_word && unit_ok && (in_q.word_offset[3] == 1'(u));

    assign ureq[u].tick = is_tick;
    assign ureq[u].rd   = is_rd && hit;
    assign ureq[u].wr   = is_wr && hit;
    assign ureq[u].sel  = dtmr_pkg::reg_e'(in_q.word_offset[2:0]);
    assign ureq[u].data = in_q.write_data;

    dtmr_unit u_timer (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .req_i  (ureq[u]),
      .rsp_o  (ursp[u])
    );
  end

  // Merge unit responses; only the addressed unit drives read data or error.
  always_comb begin
    out_d.read_data    = '0;
    out_d.access_error = 1'b0;
    for (int u = 0; u < NUM_UNITS; u++) begin
      out_d.read_data    = out_d.read_data | ursp[u].rdata;
      out_d.access_error = out_d.access_error | ursp[u].err;
    end
    if (acc) begin
      if (!in_q.access_is_word) begin
        out_d.access_error = 1'b1;
      end else if (!unit_ok) begin
        // ID words read as zero; everything else outside the blocks faults
        out_d.access_error = is_wr || !id_word;
      end
    end
    out_d.irq_first  = ursp[0].irq;
    out_d.irq_second = HasSecond ? ursp[NUM_UNITS-1].irq : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// ===== hdl/dtmr_unit.sv =====
// ----------------------------------------------------------------------------
// dtmr_unit: one down-counting timer
// Register state, prescaler, counter and register access of a single timer.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmr_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire dtmr_pkg::unit_req_t req_i,
  output dtmr_pkg::unit_rsp_t     rsp_o
);

  logic [31:0] load_q, load_d;
  logic [31:0] bg_q, bg_d;
  logic        bgp_q, bgp_d;
  logic [7:0]  ctl_q, ctl_d;
  logic        raw_q, raw_d;
  logic [31:0] count_q, count_d;
  logic        run_q, run_d;
  logic [31:0] limit_q, limit_d;
  logic [7:0]  pre_q, pre_d;

  logic [8:0]  div;
  logic        wrap;
  logic [7:0]  nc;
  logic        wr_err;
  logic        rd_err;
  logic [31:0] rdata;

  always_comb begin
    case (ctl_q[dtmr_pkg::CtlPreHi:dtmr_pkg::CtlPreLo])
      dtmr_pkg::PRE_DIV16:  div = dtmr_pkg::DIV16;
      dtmr_pkg::PRE_DIV256: div = dtmr_pkg::DIV256;
      default:              div = dtmr_pkg::DIV1;
    endcase
  end

  assign wrap = ({1'b0, pre_q} + 9'd1) >= div;
  assign nc   = req_i.data[7:0];

  // Next state.
  always_comb begin
    load_d  = load_q;
    bg_d    = bg_q;
    bgp_d   = bgp_q;
    ctl_d   = ctl_q;
    raw_d   = raw_q;
    count_d = count_q;
    run_d   = run_q;
    limit_d = limit_q;
    pre_d   = pre_q;
    wr_err  = 1'b0;

    if (req_i.tick && run_q) begin
      if (!wrap) begin
        pre_d = pre_q + 8'd1;
      end else begin
        pre_d = '0;
        if (count_q > 32'd1) begin
          count_d = count_q - 32'd1;
        end else begin
          raw_d = 1'b1;
          if (ctl_q[dtmr_pkg::CtlOneshot]) begin
            run_d   = 1'b0;
            count_d = '0;
          end else begin
            count_d = limit_q;
          end
          if (bgp_q) begin
            load_d  = bg_q;
            limit_d = bg_q;
            count_d = bg_q;
            bgp_d   = 1'b0;
          end
        end
      end
    end

    if (req_i.wr) begin
      case (req_i.sel)
        dtmr_pkg::REG_LOAD: begin
          load_d = req_i.data;
          if (ctl_q[dtmr_pkg::CtlFromLoad]) begin
            limit_d = req_i.data;
            count_d = req_i.data;
            pre_d   = '0;
          end
        end
        dtmr_pkg::REG_CONTROL: begin
          if (ctl_q[dtmr_pkg::CtlEnable] && nc[dtmr_pkg::CtlEnable]) begin
            // locked while running: drop the write
            wr_err = 1'b1;
          end else begin
            if (ctl_q[dtmr_pkg::CtlEnable]) begin
              run_d = 1'b0;
            end
            ctl_d = nc;
            if (nc[dtmr_pkg::CtlEnable] &&
                !(nc[dtmr_pkg::CtlFromLoad] && load_q == '0)) begin
              if (nc[dtmr_pkg::CtlFromLoad]) begin
                limit_d = load_q;
              end else if (nc[dtmr_pkg::CtlSize32]) begin
                limit_d = dtmr_pkg::MAX32;
              end else begin
                limit_d = dtmr_pkg::MAX16;
              end
              count_d = limit_d;
              pre_d   = '0;
              run_d   = 1'b1;
            end
          end
        end
        dtmr_pkg::REG_INTCLR: begin
          raw_d = 1'b0;
        end
        dtmr_pkg::REG_BGLOAD: begin
          bg_d = req_i.data;
          if (ctl_q[dtmr_pkg::CtlEnable] && count_q != '0) begin
            bgp_d = 1'b1;
          end else begin
            load_d = req_i.data;
            bgp_d  = 1'b0;
          end
        end
        default: begin
          wr_err = 1'b1;
        end
      endcase
    end
  end

  // Read mux on the state before the request; interrupt clear and the
  // unmapped word fault on a read.
  always_comb begin
    rdata  = '0;
    rd_err = 1'b0;
    if (req_i.rd) begin
      case (req_i.sel)
        dtmr_pkg::REG_LOAD:    rdata = load_q;
        dtmr_pkg::REG_VALUE:   rdata = count_q;
        dtmr_pkg::REG_CONTROL: rdata = {24'd0, ctl_q};
        dtmr_pkg::REG_RIS:     rdata = {31'd0, raw_q};
        dtmr_pkg::REG_MIS:     rdata = {31'd0, raw_q & ctl_q[dtmr_pkg::CtlIntEn]};
        dtmr_pkg::REG_BGLOAD:  rdata = bg_q;
        default:               rd_err = 1'b1;
      endcase
    end
  end

  // Interrupt line as it stands after this request.
  assign rsp_o = '{rdata: rdata,
                   err:   wr_err | rd_err,
                   irq:   raw_d & ctl_d[dtmr_pkg::CtlIntEn]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      bg_q    <= '0;
      bgp_q   <= 1'b0;
      ctl_q   <= dtmr_pkg::CTL_RESET;
      raw_q   <= 1'b0;
      count_q <= dtmr_pkg::MAX32;
      run_q   <= 1'b0;
      limit_q <= '0;
      pre_q   <= '0;
    end else if (en_i) begin
      load_q  <= load_d;
      bg_q    <= bg_d;
      bgp_q   <= bgp_d;
      ctl_q   <= ctl_d;
      raw_q   <= raw_d;
      count_q <= count_d;
      run_q   <= run_d;
      limit_q <= limit_d;
      pre_q   <= pre_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dtmr_checker.sv =====
// ----------------------------------------------------------------------------
// dtmr_checker: port-level checks of the dual interval timer
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmr_checker #(
  parameter int unsigned NUM_UNITS = 2
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire dtmr_pkg::in_item_t  in_req_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire dtmr_pkg::out_item_t out_rsp_o
);

  // Response register is empty once reset has been seen at an edge.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("response valid during reset");

  // A stalled response holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // Request side stalls only behind a full, stalled response register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without response backpressure");

  // Faulted accesses never return data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.access_error |-> out_rsp_o.read_data == '0)
    else $error("read data on access error");

  // With one timer the second line stays low.
  a_single_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (NUM_UNITS == 1) |-> !out_rsp_o.irq_second)
    else $error("second interrupt with one timer");

endmodule

bind dual_interval_timer dtmr_checker #(.NUM_UNITS(NUM_UNITS)) u_dtmr_checker (.*);

`default_nettype wire
